/* hw/rtl/lprs_pkg.sv */
// Shared types and constants for the linear ramp smoother.
// No dependencies; used by linear_param_ramp_smoother_unit.
`default_nettype none

package lprs_pkg;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET,
		ST_ABS,
		ST_DIV,
		ST_DIVFIN,
		ST_TICK,
		ST_MIN,
		ST_MUL,
		ST_MULFIN,
		ST_DONE
	} state_t;

	// Config register indexes.
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_CONT_MODE = 2'd0;
	localparam reg_idx_t REG_RAMP_LEN  = 2'd1;
	localparam reg_idx_t REG_TICK_DIV  = 2'd2;
	localparam reg_idx_t REG_SPT       = 2'd3;

	// Operation codes carried on s_tuser.
	localparam logic OP_SET  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam int SAMPLES_W = 21;   // ramp length / samples left
	localparam int DIVR_W    = 13;   // tick divider, samples per tick
	localparam int TCNT_W    = 12;   // tick counter
	localparam int BLOCK_W   = 25;   // samples_per_tick * divider
	localparam int FIELD_W   = 32;   // target / value_out
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_W     = 21;

	localparam logic [DIVR_W-1:0] DIV_MAX  = 13'd4096;
	localparam int                NEAR_LSB = 6;

endpackage

`default_nettype wire

/* hw/rtl/linear_param_ramp_smoother_unit.sv */
// Linear ramp smoother top level: sequencer, shared adder, divider and multiplier.
// Depends on lprs_pkg.
`default_nettype none

// Smooths one Q16.16 control value. An item with operation 0 sets a new target:
// a target within 6 LSB of the current target is ignored unless the force flag is
// set; forced, continuous_mode 0 or ramp_length 0 jump straight to it; otherwise
// a ramp starts with increment (target - value) / ramp_length, truncated toward
// zero. An item with operation 1 is a control tick; every tick_divider ticks the
// value moves by min(samples left, samples_per_tick * tick_divider) increments
// and snaps onto the target when the ramp ends. Every item gives one result.
// One item at a time. A set target that starts a ramp runs a restoring division,
// one quotient bit per cycle through the shared adder; one that is ignored or
// instant skips it. A tick that steps the ramp runs a shift-add multiply on the
// same adder; other ticks skip it. s_tready is high only while the sequencer is
// idle; a finished result waits in the output register and does not hold off the
// next item.
module linear_param_ramp_smoother_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input items
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [lprs_pkg::IN_TDATA_W-1:0]     s_tdata,  // [31:0] target, [32] force flag
	input  wire logic                                s_tuser,  // [0] operation
	// result items
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [lprs_pkg::OUT_TDATA_W-1:0]         m_tdata,  // [31:0] value_out, [32] ramping,
	                                                           // [33] stepped
	// configuration writes
	input  wire logic                                cfg_we,
	input  wire lprs_pkg::reg_idx_t                  cfg_index,
	input  wire logic [lprs_pkg::CFG_W-1:0]          cfg_wdata
);

	localparam int VW    = VALUE_WIDTH;
	localparam int DW    = VW + 1;                         // difference / dividend width
	localparam int QW    = DW + 1;                         // signed quotient width
	localparam int SW    = lprs_pkg::SAMPLES_W;
	localparam int ACC_W = VW + SW + 1;                    // value + increment * steps
	localparam int CNT_W = $clog2(ACC_W + 1);
	localparam int MUL_N = SW;

	localparam logic signed [64:0] VMAX65 = (65'sd1 <<< (VW - 1)) - 65'sd1;
	localparam logic signed [64:0] VMIN65 = -VMAX65 - 65'sd1;
	localparam logic signed [QW-1:0]    QMAX   = QW'(VMAX65);
	localparam logic signed [QW-1:0]    QMIN   = QW'(VMIN65);
	localparam logic signed [ACC_W-1:0] AMAX   = ACC_W'(VMAX65);
	localparam logic signed [ACC_W-1:0] AMIN   = ACC_W'(VMIN65);
	localparam logic signed [DW-1:0]    NEAR_P = DW'(lprs_pkg::NEAR_LSB);
	localparam logic signed [DW-1:0]    NEAR_N = -NEAR_P;

	lprs_pkg::state_t state_q, state_d;

	// config registers
	logic                              cont_q;
	logic [SW-1:0]                     rlen_q;
	logic [lprs_pkg::DIVR_W-1:0]       tdiv_q;
	logic [lprs_pkg::DIVR_W-1:0]       spt_q;

	// architectural state
	logic signed [VW-1:0]              present_q;
	logic signed [VW-1:0]              goal_q;
	logic signed [VW-1:0]              inc_q;
	logic [SW-1:0]                     left_q;
	logic [lprs_pkg::TCNT_W-1:0]       tcnt_q;

	// work registers
	logic signed [VW-1:0]              tgt_q;
	logic                              force_q;
	logic signed [DW-1:0]              diff_q;
	logic                              neg_q;
	logic [DW-1:0]                     quo_q;
	logic [SW-1:0]                     rem_q;
	logic signed [ACC_W-1:0]           acc_q;
	logic [ACC_W-1:0]                  mcand_q;
	logic [SW-1:0]                     steps_q;
	logic [lprs_pkg::BLOCK_W-1:0]      block_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              stepped_q;

	// output register
	logic                              m_valid_q;
	logic [lprs_pkg::OUT_TDATA_W-1:0]  m_data_q;

	// shared adder
	logic [ACC_W-1:0]                  add_a, add_b, add_sum;
	logic                              add_c;

	// combinational helpers
	logic signed [64:0]                t65, tgt_sat;
	logic signed [DW-1:0]              near_d;
	logic                              near, instant, out_free;
	logic [SW:0]                       rsh;
	logic                              ge;
	logic signed [QW-1:0]              qs;
	logic [lprs_pkg::DIVR_W-1:0]       div_eff, spt_eff;
	logic                              tick_wait;
	logic [SW-1:0]                     steps_d;

	assign add_sum = add_a + add_b + ACC_W'(add_c);

	// input target saturated to the value range
	assign t65     = 65'($signed(s_tdata[lprs_pkg::FIELD_W-1:0]));
	assign tgt_sat = (t65 > VMAX65) ? VMAX65 : ((t65 < VMIN65) ? VMIN65 : t65);

	assign near_d  = DW'(tgt_q) - DW'(goal_q);
	assign near    = (near_d <= NEAR_P) && (near_d >= NEAR_N) && !force_q;
	assign instant = force_q || !cont_q || (rlen_q == '0);

	// restoring divide step
	assign rsh = {rem_q, quo_q[DW-1]};
	assign ge  = !add_sum[ACC_W-1];

	assign qs = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_comb begin
		div_eff = tdiv_q;
		if (tdiv_q == '0) begin
			div_eff = lprs_pkg::DIVR_W'(1);
		end else if (tdiv_q > lprs_pkg::DIV_MAX) begin
			div_eff = lprs_pkg::DIV_MAX;
		end
		spt_eff = (spt_q == '0) ? lprs_pkg::DIVR_W'(1) : spt_q;
	end

	assign tick_wait = ({1'b0, tcnt_q} + lprs_pkg::DIVR_W'(1)) < div_eff;
	assign steps_d   = (lprs_pkg::BLOCK_W'(left_q) < block_q) ? left_q : SW'(block_q);
	assign out_free  = !m_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lprs_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == lprs_pkg::OP_TICK) ? lprs_pkg::ST_TICK : lprs_pkg::ST_SET;
				end
			end
			lprs_pkg::ST_SET: begin
				state_d = (near || instant) ? lprs_pkg::ST_DONE : lprs_pkg::ST_ABS;
			end
			lprs_pkg::ST_ABS:    state_d = lprs_pkg::ST_DIV;
			lprs_pkg::ST_DIV: begin
				if (cnt_q == CNT_W'(DW - 1)) state_d = lprs_pkg::ST_DIVFIN;
			end
			lprs_pkg::ST_DIVFIN: state_d = lprs_pkg::ST_DONE;
			lprs_pkg::ST_TICK: begin
				state_d = (tick_wait || left_q == '0) ? lprs_pkg::ST_DONE : lprs_pkg::ST_MIN;
			end
			lprs_pkg::ST_MIN:    state_d = lprs_pkg::ST_MUL;
			lprs_pkg::ST_MUL: begin
				if (cnt_q == CNT_W'(MUL_N - 1)) state_d = lprs_pkg::ST_MULFIN;
			end
			lprs_pkg::ST_MULFIN: state_d = lprs_pkg::ST_DONE;
			lprs_pkg::ST_DONE: begin
				if (out_free) state_d = lprs_pkg::ST_IDLE;
			end
			default:             state_d = lprs_pkg::ST_IDLE;
		endcase
	end

	// outputs and adder operand select
	always_comb begin
		s_tready = (state_q == lprs_pkg::ST_IDLE);
		if (state_q == lprs_pkg::ST_DIV) begin
			add_a = ACC_W'(rsh);
			add_b = ~ACC_W'(rlen_q);
			add_c = 1'b1;
		end else begin
			add_a = acc_q;
			add_b = mcand_q;
			add_c = 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lprs_pkg::ST_IDLE;
			cont_q    <= 1'b1;
			rlen_q    <= '0;
			tdiv_q    <= lprs_pkg::DIVR_W'(1);
			spt_q     <= lprs_pkg::DIVR_W'(64);
			present_q <= '0;
			goal_q    <= '0;
			inc_q     <= '0;
			left_q    <= '0;
			tcnt_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					lprs_pkg::REG_CONT_MODE: cont_q <= cfg_wdata[0];
					lprs_pkg::REG_RAMP_LEN:  rlen_q <= cfg_wdata[SW-1:0];
					lprs_pkg::REG_TICK_DIV:  tdiv_q <= cfg_wdata[lprs_pkg::DIVR_W-1:0];
					lprs_pkg::REG_SPT:       spt_q  <= cfg_wdata[lprs_pkg::DIVR_W-1:0];
					default: ;
				endcase
			end
			// a new result takes the slot the old one leaves in the same cycle
			if (state_q == lprs_pkg::ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				lprs_pkg::ST_SET: begin
					if (!near) begin
						goal_q <= tgt_q;
						if (instant) begin
							present_q <= tgt_q;
							left_q    <= '0;
						end else begin
							left_q <= rlen_q;
						end
					end
				end
				lprs_pkg::ST_DIVFIN: begin
					if (qs > QMAX)      inc_q <= VW'(QMAX);
					else if (qs < QMIN) inc_q <= VW'(QMIN);
					else                inc_q <= VW'(qs);
				end
				lprs_pkg::ST_TICK: begin
					tcnt_q <= tick_wait ? lprs_pkg::TCNT_W'(tcnt_q + 1'b1) : '0;
				end
				lprs_pkg::ST_MIN: begin
					left_q <= left_q - steps_d;
				end
				lprs_pkg::ST_MULFIN: begin
					if (left_q == '0)      present_q <= goal_q;
					else if (acc_q > AMAX) present_q <= VW'(AMAX);
					else if (acc_q < AMIN) present_q <= VW'(AMIN);
					else                   present_q <= VW'(acc_q);
				end
				default: ;
			endcase
		end
	end

	// work and output payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			lprs_pkg::ST_IDLE: begin
				tgt_q     <= VW'(tgt_sat);
				force_q   <= s_tdata[lprs_pkg::FIELD_W];
				stepped_q <= 1'b0;
			end
			lprs_pkg::ST_SET: begin
				diff_q <= DW'(tgt_q) - DW'(present_q);
			end
			lprs_pkg::ST_ABS: begin
				neg_q <= diff_q[DW-1];
				quo_q <= diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);
				rem_q <= '0;
				cnt_q <= '0;
			end
			lprs_pkg::ST_DIV: begin
				rem_q <= ge ? add_sum[SW-1:0] : rsh[SW-1:0];
				quo_q <= {quo_q[DW-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			lprs_pkg::ST_TICK: begin
				block_q <= lprs_pkg::BLOCK_W'(spt_eff) * lprs_pkg::BLOCK_W'(div_eff);
			end
			lprs_pkg::ST_MIN: begin
				steps_q <= steps_d;
				acc_q   <= ACC_W'(present_q);
				mcand_q <= ACC_W'(inc_q);
				cnt_q   <= '0;
			end
			lprs_pkg::ST_MUL: begin
				if (steps_q[0]) acc_q <= add_sum;
				mcand_q <= {mcand_q[ACC_W-2:0], 1'b0};
				steps_q <= {1'b0, steps_q[SW-1:1]};
				cnt_q   <= cnt_q + 1'b1;
			end
			lprs_pkg::ST_MULFIN: begin
				stepped_q <= 1'b1;
			end
			lprs_pkg::ST_DONE: begin
				if (out_free) begin
					m_data_q <= {(lprs_pkg::OUT_TDATA_W - lprs_pkg::FIELD_W - 2)'(0),
						stepped_q, (left_q != '0), lprs_pkg::FIELD_W'(present_q)};
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// one item at a time: an accepted item holds off the next
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while sequencer busy");

	// division only runs with a nonzero ramp length
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lprs_pkg::ST_DIV |-> rlen_q != '0)
		else $error("divide by zero ramp length");

	// with no ramp active the value sits on the target
	a_settled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lprs_pkg::ST_IDLE && left_q == '0 |-> present_q == goal_q)
		else $error("value off target with no ramp active");

	// a step that ends the ramp lands on the target value
	a_snap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lprs_pkg::ST_MULFIN && left_q == '0 |=> present_q == goal_q)
		else $error("ramp end did not snap to target");
`endif

endmodule

`default_nettype wire

/* tb/sv/smoother_monitor.sv */
// Monitor for linear_param_ramp_smoother_unit: watches the item, result and config ports,
// predicts every result and compares it field by field.
// Depends on lprs_pkg.
module smoother_monitor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [lprs_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] target, [32] force flag
	input  logic                             s_tuser,   // [0] operation
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [lprs_pkg::OUT_TDATA_W-1:0] m_tdata,   // [31:0] value_out, [32] ramping,
	                                                    // [33] stepped
	input  logic                             cfg_we,
	input  lprs_pkg::reg_idx_t               cfg_index,
	input  logic [lprs_pkg::CFG_W-1:0]       cfg_wdata,
	output int                               results_due,
	output int                               mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [lprs_pkg::FIELD_W-1:0] value;
		logic                         ramping;
		logic                         stepped;
	} smoothed_t;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -Q_MAX - 1;

	// mirrored registers
	logic                           cont_mode;
	logic [lprs_pkg::SAMPLES_W-1:0] ramp_len;
	logic [lprs_pkg::DIVR_W-1:0]    tick_div;
	logic [lprs_pkg::DIVR_W-1:0]    spt;

	// mirrored smoother state
	longint cur_val, goal_val, step_inc, samples_rem, tick_cnt;

	smoothed_t smoothed_due[$];
	int        results_seen;

	function automatic longint clamp_q(input longint v);
		if (v > Q_MAX)
			return Q_MAX;
		if (v < Q_MIN)
			return Q_MIN;
		return v;
	endfunction

	// Applies one item to the mirrored state and returns the result it should give.
	function automatic smoothed_t step_smoother(input logic op,
			input logic [lprs_pkg::FIELD_W-1:0] tgt_bits, input logic frc);
		longint    tgt, gap, div_eff, spt_eff, span, steps;
		logic      moved;
		smoothed_t r;
		moved = 1'b0;
		if (op == lprs_pkg::OP_SET) begin
			tgt = clamp_q(longint'(signed'(tgt_bits)));
			gap = tgt - goal_val;
			if (gap < 0)
				gap = -gap;
			if (gap > lprs_pkg::NEAR_LSB || frc) begin
				goal_val = tgt;
				if (frc || !cont_mode || ramp_len == 0) begin
					cur_val     = goal_val;
					samples_rem = 0;
				end else begin
					samples_rem = longint'(ramp_len);
					step_inc    = clamp_q((goal_val - cur_val) / longint'(ramp_len));
				end
			end
		end else begin
			div_eff = (tick_div == 0) ? 1 : longint'(tick_div);
			if (div_eff > longint'(lprs_pkg::DIV_MAX))
				div_eff = longint'(lprs_pkg::DIV_MAX);
			spt_eff = (spt == 0) ? 1 : longint'(spt);
			if (tick_cnt + 1 < div_eff) begin
				tick_cnt = (tick_cnt + 1) & 64'hFFF;
			end else begin
				tick_cnt = 0;
				if (samples_rem != 0) begin
					span  = spt_eff * div_eff;
					steps = (samples_rem < span) ? samples_rem : span;
					cur_val = clamp_q(cur_val + step_inc * steps);
					samples_rem -= steps;
					if (samples_rem == 0)
						cur_val = goal_val;
					moved = 1'b1;
				end
			end
		end
		r.value   = cur_val[lprs_pkg::FIELD_W-1:0];
		r.ramping = (samples_rem != 0);
		r.stepped = moved;
		return r;
	endfunction

	task automatic log_mismatch(input string what, input logic [lprs_pkg::FIELD_W-1:0] got,
			input logic [lprs_pkg::FIELD_W-1:0] want);
		$display("[%0t] result %0d: %s got %h expected %h", $time, results_seen, what,
			got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		smoothed_t seen, due;
		if (!arst_n) begin
			cont_mode      = 1'b1;
			ramp_len       = '0;
			tick_div       = lprs_pkg::DIVR_W'(1);
			spt            = lprs_pkg::DIVR_W'(64);
			cur_val        = 0;
			goal_val       = 0;
			step_inc       = 0;
			samples_rem    = 0;
			tick_cnt       = 0;
			results_seen   = 0;
			mismatch_count = 0;
			smoothed_due.delete();
			results_due    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lprs_pkg::REG_CONT_MODE: cont_mode = cfg_wdata[0];
					lprs_pkg::REG_RAMP_LEN:  ramp_len  = cfg_wdata[lprs_pkg::SAMPLES_W-1:0];
					lprs_pkg::REG_TICK_DIV:  tick_div  = cfg_wdata[lprs_pkg::DIVR_W-1:0];
					lprs_pkg::REG_SPT:       spt       = cfg_wdata[lprs_pkg::DIVR_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				smoothed_due.insert(smoothed_due.size(),
					step_smoother(s_tuser, s_tdata[lprs_pkg::FIELD_W-1:0],
					s_tdata[lprs_pkg::FIELD_W]));
			if (m_tvalid && m_tready) begin
				seen.value   = m_tdata[lprs_pkg::FIELD_W-1:0];
				seen.ramping = m_tdata[lprs_pkg::FIELD_W];
				seen.stepped = m_tdata[lprs_pkg::FIELD_W+1];
				if (smoothed_due.size() == 0) begin
					log_mismatch("unexpected result, value_out", seen.value, '0);
				end else begin
					due = smoothed_due.pop_front();
					if (seen.value !== due.value)
						log_mismatch("value_out", seen.value, due.value);
					if (seen.ramping !== due.ramping)
						log_mismatch("ramping", lprs_pkg::FIELD_W'(seen.ramping),
							lprs_pkg::FIELD_W'(due.ramping));
					if (seen.stepped !== due.stepped)
						log_mismatch("stepped", lprs_pkg::FIELD_W'(seen.stepped),
							lprs_pkg::FIELD_W'(due.stepped));
				end
				results_seen++;
			end
			results_due = smoothed_due.size();
		end
	end

endmodule

/* tb/sv/testbench.sv */
// Top of the ramp smoother regression: clock, reset, stimulus and verdict.
// Depends on lprs_pkg, smoother_monitor and linear_param_ramp_smoother_unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     RANDOM_ITEMS  = 1750;
	localparam int     SAT_TICKS     = 12;    // a few ticks under a saturated divider
	localparam int     SETTLE_CYCLES = 64;    // extra wait once every result is back
	localparam longint CYCLE_LIMIT   = 64'd1_000_000;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [lprs_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;    // [31:0] target, [32] force flag
	logic                             s_tuser   = lprs_pkg::OP_SET; // [0] operation
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [lprs_pkg::OUT_TDATA_W-1:0] m_tdata;           // [31:0] value_out, [32] ramping,
	                                                     // [33] stepped
	logic                             cfg_we    = 1'b0;
	lprs_pkg::reg_idx_t               cfg_index = lprs_pkg::REG_CONT_MODE;
	logic [lprs_pkg::CFG_W-1:0]       cfg_wdata = '0;

	int     results_due;
	int     mismatch_count;
	logic   no_gaps     = 1'b0;   // disables idling on both sides
	longint cycle_cnt   = 0;
	logic [lprs_pkg::FIELD_W-1:0] last_target = '0;  // rough copy of the goal, for near targets

	always #1 clk = ~clk;

	linear_param_ramp_smoother_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	smoother_monitor u_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.results_due    (results_due),
		.mismatch_count (mismatch_count)
	);

	// Result side: stalls ~18% of cycles unless a quiet stretch is running.
	always @(posedge clk) begin
		m_tready <= no_gaps || ($urandom_range(99) >= 18);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("linear_param_ramp_smoother_unit regression: fail");
			$finish;
		end
	end

	// Offers one item and returns at the edge where it is taken, tvalid still high.
	// The next call (or settle) lowers or reuses tvalid in that same step.
	task automatic send_item(input logic op, input logic [lprs_pkg::FIELD_W-1:0] tgt,
			input logic frc);
		if (!no_gaps) begin
			while ($urandom_range(99) < 18) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(lprs_pkg::IN_TDATA_W-lprs_pkg::FIELD_W-1){1'b0}}, frc, tgt};
		if (op == lprs_pkg::OP_SET)
			last_target = tgt;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send_tick();
		send_item(lprs_pkg::OP_TICK, $urandom(), 1'($urandom_range(1)));
	endtask

	// Stop sending and wait until every predicted result has come back.
	task automatic settle(input int extra);
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (results_due != 0);
		repeat (extra) @(posedge clk);
	endtask

	// Only called with the block idle.
	task automatic write_reg(input lprs_pkg::reg_idx_t idx,
			input logic [lprs_pkg::CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Random register set for one phase; short ramps and small dividers dominate so
	// that ramps run to completion often.
	task automatic pick_config();
		logic [lprs_pkg::CFG_W-1:0] len, dv, sp;
		case ($urandom_range(9))
			0:       len = '0;
			1:       len = lprs_pkg::CFG_W'(1);
			2, 3, 4, 5: len = lprs_pkg::CFG_W'($urandom_range(16, 2));
			6, 7:    len = lprs_pkg::CFG_W'($urandom_range(4096, 17));
			8:       len = lprs_pkg::CFG_W'($urandom_range(1048576, 4097));
			default: len = ($urandom_range(1) != 0) ? lprs_pkg::CFG_W'(1048576) :
				lprs_pkg::CFG_W'($urandom_range(2097151, 1048577));
		endcase
		case ($urandom_range(19))
			0:       dv = '0;
			1:       dv = lprs_pkg::CFG_W'(4096);
			2:       dv = lprs_pkg::CFG_W'(8191);
			3, 4, 5: dv = lprs_pkg::CFG_W'($urandom_range(64, 5));
			default: dv = lprs_pkg::CFG_W'($urandom_range(4, 1));
		endcase
		case ($urandom_range(11))
			0:       sp = '0;
			1:       sp = lprs_pkg::CFG_W'(4096);
			2:       sp = lprs_pkg::CFG_W'(8191);
			3:       sp = lprs_pkg::CFG_W'($urandom_range(8191, 65));
			default: sp = lprs_pkg::CFG_W'($urandom_range(64, 1));
		endcase
		write_reg(lprs_pkg::REG_CONT_MODE,
			($urandom_range(99) < 85) ? lprs_pkg::CFG_W'(1) : lprs_pkg::CFG_W'(0));
		write_reg(lprs_pkg::REG_RAMP_LEN, len);
		write_reg(lprs_pkg::REG_TICK_DIV, dv);
		write_reg(lprs_pkg::REG_SPT, sp);
	endtask

	// Mostly ticks to move ramps along; set items pick random, near-equal, small or
	// extreme targets.
	task automatic random_item();
		logic [lprs_pkg::FIELD_W-1:0] tgt;
		if ($urandom_range(99) >= 30) begin
			send_tick();
		end else begin
			case ($urandom_range(9))
				0, 1, 2, 3: tgt = $urandom();
				4, 5:       tgt = last_target + $urandom_range(16) - 32'd8;
				6, 7:       tgt = $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
				8: begin
					case ($urandom_range(3))
						0:       tgt = 32'h7FFF_FFFF;
						1:       tgt = 32'h8000_0000;
						2:       tgt = '0;
						default: tgt = '1;
					endcase
				end
				default:    tgt = last_target;
			endcase
			send_item(lprs_pkg::OP_SET, tgt, $urandom_range(99) < 10);
		end
	endtask

	initial begin
		int sent, phase, phase_len;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, reset registers: ramp_length 0 so every change is instant
		send_item(lprs_pkg::OP_SET, 32'h7FFF_FFFF, 1'b0);
		send_item(lprs_pkg::OP_SET, 32'h7FFF_FFF9, 1'b0);  // exactly 6 LSB away: ignored
		send_item(lprs_pkg::OP_SET, 32'h7FFF_FFF8, 1'b0);  // 7 LSB away: taken
		send_item(lprs_pkg::OP_SET, 32'h8000_0000, 1'b0);
		send_item(lprs_pkg::OP_SET, 32'h8000_0000, 1'b1);  // forced although unchanged
		send_item(lprs_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b1); // no ramp: counter only

		// one-sample ramps across the full range: increment saturates both ways
		settle(2);
		write_reg(lprs_pkg::REG_RAMP_LEN, lprs_pkg::CFG_W'(1));
		send_item(lprs_pkg::OP_SET, 32'h7FFF_FFFF, 1'b0);
		send_tick();
		send_item(lprs_pkg::OP_SET, 32'h8000_0000, 1'b0);
		send_tick();

		// ramp length 1048576, divider 3: only the third tick steps
		settle(2);
		write_reg(lprs_pkg::REG_RAMP_LEN, lprs_pkg::CFG_W'(1048576));
		write_reg(lprs_pkg::REG_TICK_DIV, lprs_pkg::CFG_W'(3));
		write_reg(lprs_pkg::REG_SPT, lprs_pkg::CFG_W'(1));
		send_item(lprs_pkg::OP_SET, 32'h0000_0000, 1'b0);
		repeat (3) send_tick();
		send_item(lprs_pkg::OP_SET, 32'h0001_0000, 1'b1);  // forced jump mid-ramp

		// continuous mode off
		settle(2);
		write_reg(lprs_pkg::REG_CONT_MODE, lprs_pkg::CFG_W'(0));
		send_item(lprs_pkg::OP_SET, 32'hFFFF_0000, 1'b0);

		// counter left above a smaller divider fires on the next tick
		settle(2);
		write_reg(lprs_pkg::REG_CONT_MODE, lprs_pkg::CFG_W'(1));
		write_reg(lprs_pkg::REG_TICK_DIV, lprs_pkg::CFG_W'(100));
		write_reg(lprs_pkg::REG_RAMP_LEN, lprs_pkg::CFG_W'(5));
		send_item(lprs_pkg::OP_SET, 32'h0005_0000, 1'b0);
		repeat (5) send_tick();
		settle(2);
		write_reg(lprs_pkg::REG_TICK_DIV, lprs_pkg::CFG_W'(2));
		send_tick();

		// zero divider and zero samples_per_tick behave as 1
		settle(2);
		write_reg(lprs_pkg::REG_TICK_DIV, lprs_pkg::CFG_W'(0));
		write_reg(lprs_pkg::REG_SPT, lprs_pkg::CFG_W'(0));
		repeat (2) send_tick();

		// Divider above the maximum saturates to 4096; a short run of ticks without
		// any idling only moves the counter.
		settle(2);
		no_gaps <= 1'b1;
		write_reg(lprs_pkg::REG_TICK_DIV, lprs_pkg::CFG_W'(8191));
		write_reg(lprs_pkg::REG_SPT, lprs_pkg::CFG_W'(4096));
		write_reg(lprs_pkg::REG_RAMP_LEN, lprs_pkg::CFG_W'(1048576));
		send_item(lprs_pkg::OP_SET, 32'h0000_0000, 1'b1);
		send_item(lprs_pkg::OP_SET, 32'h4000_0000, 1'b0);
		repeat (SAT_TICKS) send_tick();
		settle(2);
		no_gaps <= 1'b0;

		// --- random phases; each begins from an idle block with fresh registers
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			settle(2);
			no_gaps <= (phase == 5);  // one more quiet stretch
			pick_config();
			phase_len = $urandom_range(80, 20);
			repeat (phase_len) random_item();
			sent += phase_len;
			phase++;
		end

		settle(SETTLE_CYCLES);
		@(negedge clk);
		if (mismatch_count == 0) begin
			$display("linear_param_ramp_smoother_unit regression: pass");
		end else begin
			$display("linear_param_ramp_smoother_unit regression: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/lprs_pkg.sv
hw/rtl/linear_param_ramp_smoother_unit.sv
tb/sv/smoother_monitor.sv
tb/sv/testbench.sv
